FILE: rtl/ffbp_pkg.sv
// Shared types and constants for the first-fit bin packer.
// Used by the controller, the datapath and the top level; no dependencies.
package ffbp_pkg;

  // operation codes of an input item
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_PLACE = 2'd1;
  localparam logic [1:0] OP_CLEAR = 2'd2;

  // result status codes
  localparam logic [2:0] RES_LOADED    = 3'd0;
  localparam logic [2:0] RES_PLACED    = 3'd1;
  localparam logic [2:0] RES_EMPTY     = 3'd2;
  localparam logic [2:0] RES_FULL      = 3'd3;
  localparam logic [2:0] RES_EXHAUSTED = 3'd4;

  // configuration register indexes
  localparam logic CFG_BIN_CAPACITY = 1'b0;
  localparam logic CFG_MIN_FRAGMENT = 1'b1;

  typedef enum logic [3:0] {
    S_IDLE,
    S_DISPATCH,
    S_HEAD_EV,
    S_BIN_RD,
    S_BIN_EV,
    S_WALK_RD,
    S_WALK_EV,
    S_RESULT
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic latch_in;
    logic load;
    logic full;
    logic clear;
    logic empty;
    logic rd_head;
    logic latch_head;
    logic rd_bin;
    logic bin_next;
    logic place_whole;
    logic place_split;
    logic open_bin;
    logic exhausted;
    logic walk_rd;
    logic walk_shift;
    logic walk_insert;
    logic emit;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic [1:0] op;
    logic       list_full;
    logic       list_empty;
    logic       bin_in_range;
    logic       bins_full;
    logic       fits;
    logic       can_split;
    logic       walk_in_range;
    logic       walk_move;
    logic       out_free;
  } stat_t;

endpackage

FILE: rtl/ffbp_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module ffbp_ram #(
  parameter int Width = 16,
  parameter int Depth = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/ffbp_ctrl.sv
// Controller state machine of the bin packer.
// Depends on ffbp_pkg; drives datapath commands from datapath status.
module ffbp_ctrl import ffbp_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_stall_o,
  input  stat_t stat_i,
  output cmd_t  cmd_o
);

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        case (stat_i.op)
          OP_LOAD, OP_CLEAR: state_d = S_RESULT;
          OP_PLACE: state_d = stat_i.list_empty ? S_RESULT : S_HEAD_EV;
          default: state_d = S_IDLE;
        endcase
      end
      S_HEAD_EV: state_d = S_BIN_RD;
      S_BIN_RD: begin
        state_d = stat_i.bin_in_range ? S_BIN_EV : S_RESULT;
      end
      S_BIN_EV: begin
        if (stat_i.fits) state_d = S_RESULT;
        else if (stat_i.can_split) state_d = S_WALK_RD;
        else state_d = S_BIN_RD;
      end
      S_WALK_RD: begin
        state_d = stat_i.walk_in_range ? S_WALK_EV : S_RESULT;
      end
      S_WALK_EV: begin
        state_d = stat_i.walk_move ? S_WALK_RD : S_RESULT;
      end
      S_RESULT: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd_o = '0;
    in_stall_o = (state_q != S_IDLE);
    case (state_q)
      S_IDLE: cmd_o.latch_in = in_valid_i;
      S_DISPATCH: begin
        case (stat_i.op)
          OP_LOAD: begin
            cmd_o.load = !stat_i.list_full;
            cmd_o.full = stat_i.list_full;
          end
          OP_CLEAR: cmd_o.clear = 1'b1;
          OP_PLACE: begin
            cmd_o.empty   = stat_i.list_empty;
            cmd_o.rd_head = !stat_i.list_empty;
          end
          default: ;
        endcase
      end
      S_HEAD_EV: cmd_o.latch_head = 1'b1;
      S_BIN_RD: begin
        cmd_o.rd_bin    = stat_i.bin_in_range;
        cmd_o.exhausted = !stat_i.bin_in_range && stat_i.bins_full;
        cmd_o.open_bin  = !stat_i.bin_in_range && !stat_i.bins_full;
      end
      S_BIN_EV: begin
        cmd_o.place_whole = stat_i.fits;
        cmd_o.place_split = !stat_i.fits && stat_i.can_split;
        cmd_o.bin_next    = !stat_i.fits && !stat_i.can_split;
      end
      S_WALK_RD: begin
        cmd_o.walk_rd     = stat_i.walk_in_range;
        cmd_o.walk_insert = !stat_i.walk_in_range;
      end
      S_WALK_EV: begin
        cmd_o.walk_shift  = stat_i.walk_move;
        cmd_o.walk_insert = !stat_i.walk_move;
      end
      S_RESULT: cmd_o.emit = stat_i.out_free;
      default: ;
    endcase
  end

endmodule

FILE: rtl/ffbp_dp.sv
// Datapath of the bin packer: pending list (circular buffer in RAM), bin
// fill RAM, config registers, scan/walk counters and result register.
// Depends on ffbp_pkg and ffbp_ram.
module ffbp_dp import ffbp_pkg::*; #(
  parameter int MaxItems = 256,
  parameter int MaxBins  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic [1:0]  operation_i,
  input  logic [15:0] item_value_i,
  input  logic [15:0] item_id_i,
  input  cmd_t        cmd_i,
  output stat_t       stat_o,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  bin_number_o,
  output logic [15:0] placed_id_o,
  output logic [15:0] placed_amount_o,
  output logic        opened_bin_o,
  output logic        was_split_o,
  output logic [8:0]  items_left_o
);

  localparam int IAW = $clog2(MaxItems);
  localparam int ICW = $clog2(MaxItems + 1);
  localparam int BAW = $clog2(MaxBins);
  localparam int BCW = $clog2(MaxBins + 1);

  function automatic logic [IAW-1:0] wrap_inc(input logic [IAW-1:0] p);
    wrap_inc = (p == IAW'(MaxItems - 1)) ? '0 : p + 1'b1;
  endfunction

  // config registers
  logic [15:0] cap_q, minf_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cap_q  <= 16'd100;
      minf_q <= 16'd0;
    end else if (cfg_we_i) begin
      if (cfg_index_i == CFG_BIN_CAPACITY) cap_q <= cfg_data_i;
      else minf_q <= cfg_data_i;
    end
  end

  // latched input item
  logic [1:0]  op_q;
  logic [15:0] in_val_q, in_id_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_in) begin
      op_q     <= operation_i;
      in_val_q <= item_value_i;
      in_id_q  <= item_id_i;
    end
  end

  // list and bin control state
  logic [IAW-1:0] head_q, prev_q, cur_q;
  logic [ICW-1:0] count_q, j_q;
  logic [BCW-1:0] nbins_q, bi_q;
  logic [15:0]    hv_q, hid_q, rest_q;

  // RAMs
  logic           p_we, p_re;
  logic [IAW-1:0] p_waddr, p_raddr;
  logic [31:0]    p_wdata, p_rdata;
  logic           b_we;
  logic [BAW-1:0] b_waddr;
  logic [16:0]    b_wdata, b_rdata;

  ffbp_ram #(.Width(32), .Depth(MaxItems)) u_list_ram (
    .clk_i, .we_i(p_we), .waddr_i(p_waddr), .wdata_i(p_wdata),
    .re_i(p_re), .raddr_i(p_raddr), .rdata_o(p_rdata)
  );

  ffbp_ram #(.Width(17), .Depth(MaxBins)) u_bin_ram (
    .clk_i, .we_i(b_we), .waddr_i(b_waddr), .wdata_i(b_wdata),
    .re_i(cmd_i.rd_bin), .raddr_i(bi_q[BAW-1:0]), .rdata_o(b_rdata)
  );

  // tail position of the circular list
  logic [ICW:0]   tail_sum;
  logic [IAW-1:0] tail;
  assign tail_sum = (ICW+1)'(head_q) + (ICW+1)'(count_q);
  assign tail = (tail_sum >= (ICW+1)'(MaxItems)) ?
                IAW'(tail_sum - (ICW+1)'(MaxItems)) : IAW'(tail_sum);

  // bin evaluation
  logic signed [17:0] free_sp;
  logic [15:0]        v_minus_b, piece;
  logic               fits, can_split;
  assign free_sp   = $signed({2'b00, cap_q}) - $signed({1'b0, b_rdata});
  assign fits      = free_sp >= $signed({2'b00, hv_q});
  assign can_split = !free_sp[17] && (free_sp != '0)
                     && (free_sp >= $signed({2'b00, minf_q}))
                     && ({1'b0, hv_q} >= {minf_q, 1'b0});
  assign v_minus_b = hv_q - minf_q;
  assign piece     = (free_sp < $signed({2'b00, v_minus_b})) ? free_sp[15:0] : v_minus_b;

  // RAM port control
  always_comb begin
    p_we    = 1'b0;
    p_waddr = prev_q;
    p_wdata = p_rdata;
    if (cmd_i.load) begin
      p_we    = 1'b1;
      p_waddr = tail;
      p_wdata = {in_val_q, in_id_q};
    end else if (cmd_i.walk_shift) begin
      p_we = 1'b1;
    end else if (cmd_i.walk_insert) begin
      p_we    = 1'b1;
      p_wdata = {rest_q, hid_q};
    end
    p_re    = cmd_i.rd_head || cmd_i.walk_rd;
    p_raddr = cmd_i.rd_head ? head_q : cur_q;

    b_we    = cmd_i.place_whole || cmd_i.place_split || cmd_i.open_bin;
    b_waddr = cmd_i.open_bin ? nbins_q[BAW-1:0] : bi_q[BAW-1:0];
    b_wdata = cmd_i.open_bin    ? {1'b0, hv_q} :
              cmd_i.place_whole ? b_rdata + {1'b0, hv_q} :
                                  b_rdata + {1'b0, piece};
  end

  // result staging
  logic [2:0]     r_status_q;
  logic [BAW-1:0] r_bin_q;
  logic [15:0]    r_id_q, r_amt_q;
  logic           r_open_q, r_split_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      count_q <= '0;
      nbins_q <= '0;
    end else begin
      if (cmd_i.load) count_q <= count_q + 1'b1;
      if (cmd_i.clear) begin
        count_q <= '0;
        nbins_q <= '0;
        head_q  <= '0;
      end
      if (cmd_i.place_whole || cmd_i.open_bin) begin
        head_q  <= wrap_inc(head_q);
        count_q <= count_q - 1'b1;
      end
      if (cmd_i.open_bin) nbins_q <= nbins_q + 1'b1;
    end
  end

  // scan, walk and result payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch_head) begin
      hv_q  <= p_rdata[31:16];
      hid_q <= p_rdata[15:0];
      bi_q  <= '0;
    end
    if (cmd_i.bin_next) bi_q <= bi_q + 1'b1;
    if (cmd_i.place_split) begin
      rest_q <= hv_q - piece;
      prev_q <= head_q;
      cur_q  <= wrap_inc(head_q);
      j_q    <= ICW'(1);
    end
    if (cmd_i.walk_shift) begin
      prev_q <= cur_q;
      cur_q  <= wrap_inc(cur_q);
      j_q    <= j_q + 1'b1;
    end
    if (cmd_i.load || cmd_i.full || cmd_i.clear || cmd_i.empty || cmd_i.exhausted) begin
      r_status_q <= cmd_i.load ? RES_LOADED :
                    cmd_i.full ? RES_FULL :
                    cmd_i.exhausted ? RES_EXHAUSTED : RES_EMPTY;
      r_bin_q   <= '0;
      r_id_q    <= '0;
      r_amt_q   <= '0;
      r_open_q  <= 1'b0;
      r_split_q <= 1'b0;
    end
    if (cmd_i.place_whole || cmd_i.place_split || cmd_i.open_bin) begin
      r_status_q <= RES_PLACED;
      r_bin_q    <= cmd_i.open_bin ? nbins_q[BAW-1:0] : bi_q[BAW-1:0];
      r_id_q     <= hid_q;
      r_amt_q    <= cmd_i.place_split ? piece : hv_q;
      r_open_q   <= cmd_i.open_bin;
      r_split_q  <= cmd_i.place_split;
    end
  end

  // output register
  logic out_valid_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      status_o        <= r_status_q;
      bin_number_o    <= 8'(r_bin_q);
      placed_id_o     <= r_id_q;
      placed_amount_o <= r_amt_q;
      opened_bin_o    <= r_open_q;
      was_split_o     <= r_split_q;
      items_left_o    <= 9'(count_q);
    end
  end
  assign out_valid_o = out_valid_q;

  // status to controller
  always_comb begin
    stat_o.op            = op_q;
    stat_o.list_full     = (count_q == ICW'(MaxItems));
    stat_o.list_empty    = (count_q == '0);
    stat_o.bin_in_range  = (bi_q < nbins_q);
    stat_o.bins_full     = (nbins_q == BCW'(MaxBins));
    stat_o.fits          = fits;
    stat_o.can_split     = can_split;
    stat_o.walk_in_range = (j_q < count_q);
    stat_o.walk_move     = (p_rdata[31:16] >= rest_q);
    stat_o.out_free      = !out_valid_q || !out_stall_i;
  end

endmodule

FILE: rtl/first_fit_bin_packing_with_splitting.sv
// First-fit bin packer with splittable items; top level.
// A load, clear or list-empty result is staged in dispatch and registered at
// the output from the result state; no new item is accepted until then.
// A place adds a scan over the bins (fill RAM read, then compare) and, for a
// split, a walk over list entries (read, then compare) for a sorted requeue.
// One item is in work at a time. Reset clears counts and config (capacity 100).
module first_fit_bin_packing_with_splitting import ffbp_pkg::*; #(
  parameter int MaxItems = 256,
  parameter int MaxBins  = 256
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  operation_i,
  input  logic [15:0] item_value_i,
  input  logic [15:0] item_id_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [2:0]  status_o,
  output logic [7:0]  bin_number_o,
  output logic [15:0] placed_id_o,
  output logic [15:0] placed_amount_o,
  output logic        opened_bin_o,
  output logic        was_split_o,
  output logic [8:0]  items_left_o
);

  cmd_t  cmd;
  stat_t stat;

  ffbp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid_i, .in_stall_o, .stat_i(stat), .cmd_o(cmd)
  );

  ffbp_dp #(.MaxItems(MaxItems), .MaxBins(MaxBins)) u_dp (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_index_i, .cfg_data_i,
    .operation_i, .item_value_i, .item_id_i,
    .cmd_i(cmd), .stat_o(stat),
    .out_valid_o, .out_stall_i, .status_o, .bin_number_o, .placed_id_o,
    .placed_amount_o, .opened_bin_o, .was_split_o, .items_left_o
  );

endmodule

FILE: test/first_fit_bin_packing_with_splitting_tb.sv
// Self-checking testbench for the first-fit bin packer with splittable items.
// Depends on ffbp_pkg and first_fit_bin_packing_with_splitting; an internal
// predictor models the pending list and the bin fills to check every result.
`timescale 1ns / 1ps

module first_fit_bin_packing_with_splitting_tb;
  import ffbp_pkg::*;

  localparam int NumItems = 256;
  localparam int NumBins  = 256;
  localparam int DrainCycles = 2500;
  localparam longint CycleLimit = 5000000;
  // operation code with no meaning; the block drops such an item
  localparam logic [1:0] OpIgnored = 2'd3;

  typedef struct packed {
    logic [1:0]  op;
    logic [15:0] value;
    logic [15:0] id;
  } pack_req_t;

  typedef struct packed {
    logic [2:0]  status;
    logic [7:0]  bin;
    logic [15:0] id;
    logic [15:0] amount;
    logic        opened;
    logic        split;
    logic [8:0]  left;
  } pack_res_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [1:0]  operation_i = '0;
  logic [15:0] item_value_i = '0;
  logic [15:0] item_id_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [2:0]  status_o;
  logic [7:0]  bin_number_o;
  logic [15:0] placed_id_o;
  logic [15:0] placed_amount_o;
  logic        opened_bin_o;
  logic        was_split_o;
  logic [8:0]  items_left_o;

  // packer model state
  int unsigned capacity = 100;
  int unsigned min_frag = 0;
  int unsigned pend_val [NumItems];
  int unsigned pend_id  [NumItems];
  int unsigned pend_cnt = 0;
  int unsigned bin_fill [NumBins];
  int unsigned bin_cnt = 0;

  pack_req_t   req_q[$];
  pack_res_t   result_q[$];
  int          sender_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          fail_cnt = 0;
  int          checked_cnt = 0;
  int          placed_cnt = 0;
  int          split_cnt = 0;
  int          exhaust_cnt = 0;
  int          full_cnt = 0;
  longint      cycle_cnt = 0;

  first_fit_bin_packing_with_splitting i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .operation_i    (operation_i),
    .item_value_i   (item_value_i),
    .item_id_i      (item_id_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .status_o       (status_o),
    .bin_number_o   (bin_number_o),
    .placed_id_o    (placed_id_o),
    .placed_amount_o(placed_amount_o),
    .opened_bin_o   (opened_bin_o),
    .was_split_o    (was_split_o),
    .items_left_o   (items_left_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt > CycleLimit) begin
      $display("first_fit_bin_packing_with_splitting_tb: done, errors");
      $finish;
    end
  end

  function automatic void drop_head();
    for (int k = 1; k < pend_cnt; k++) begin
      pend_val[k-1] = pend_val[k];
      pend_id[k-1]  = pend_id[k];
    end
    pend_cnt--;
  endfunction

  // Compute the expected result of one accepted item and update the model.
  function automatic void pack_predict(logic [1:0] op, logic [15:0] v, logic [15:0] id);
    pack_res_t   r;
    longint      free_sp, piece, frag, hv;
    int unsigned hid, rest, pos;
    bit          done;
    r = '0;
    done = 1'b0;
    frag = longint'(min_frag);
    if (op == OpIgnored) return;
    if (op == OP_LOAD) begin
      if (pend_cnt >= NumItems) begin
        r.status = RES_FULL;
      end else begin
        pend_val[pend_cnt] = v;
        pend_id[pend_cnt]  = id;
        pend_cnt++;
        r.status = RES_LOADED;
      end
    end else if (op == OP_CLEAR) begin
      pend_cnt = 0;
      bin_cnt = 0;
      r.status = RES_EMPTY;
    end else if (pend_cnt == 0) begin
      r.status = RES_EMPTY;
    end else begin
      hv  = longint'(pend_val[0]);
      hid = pend_id[0];
      // first-fit scan over open bins
      for (int i = 0; i < bin_cnt && !done; i++) begin
        free_sp = longint'(capacity) - longint'(bin_fill[i]);
        if (free_sp >= hv) begin
          bin_fill[i] += int'(hv);
          drop_head();
          r = '{RES_PLACED, i[7:0], hid[15:0], hv[15:0], 1'b0, 1'b0, 9'd0};
          done = 1'b1;
        end else if (free_sp >= frag && free_sp != 0 && hv >= 2 * frag) begin
          piece = hv - frag;
          if (free_sp < piece) piece = free_sp;
          bin_fill[i] += int'(piece);
          rest = int'(hv - piece);
          drop_head();
          // requeue the remainder before the first smaller entry
          pos = 0;
          while (pos < pend_cnt && pend_val[pos] >= rest) pos++;
          for (int k = pend_cnt; k > pos; k--) begin
            pend_val[k] = pend_val[k-1];
            pend_id[k]  = pend_id[k-1];
          end
          pend_val[pos] = rest;
          pend_id[pos]  = hid;
          pend_cnt++;
          r = '{RES_PLACED, i[7:0], hid[15:0], piece[15:0], 1'b0, 1'b1, 9'd0};
          split_cnt++;
          done = 1'b1;
        end
      end
      if (!done) begin
        if (bin_cnt >= NumBins) begin
          r.status = RES_EXHAUSTED;
          exhaust_cnt++;
        end else begin
          bin_fill[bin_cnt] = int'(hv);
          bin_cnt++;
          drop_head();
          r = '{RES_PLACED, 8'(bin_cnt - 1), hid[15:0], hv[15:0], 1'b1, 1'b0, 9'd0};
        end
      end
      if (r.status == RES_PLACED) placed_cnt++;
    end
    if (r.status == RES_FULL) full_cnt++;
    r.left = 9'(pend_cnt);
    result_q.insert(result_q.size(), r);
  endfunction

  // Driver: present queued items, predict on each accepted one.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else begin
      pack_req_t nxt;
      if (in_valid_i && !in_stall_o) pack_predict(operation_i, item_value_i, item_id_i);
      if (!in_valid_i || !in_stall_o) begin
        if (req_q.size() > 0 && $urandom_range(99) >= sender_idle_pct) begin
          nxt = req_q[0];
          req_q.delete(0);
          in_valid_i   <= 1'b1;
          operation_i  <= nxt.op;
          item_value_i <= nxt.value;
          item_id_i    <= nxt.id;
        end else begin
          in_valid_i <= 1'b0;
        end
      end
    end
  end

  // Monitor: compare each accepted result with the oldest expectation.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      pack_res_t e;
      if (out_valid_o && !out_stall_i) begin
        if (result_q.size() == 0) begin
          $error("unexpected result: status %0d", status_o);
          fail_cnt++;
        end else begin
          e = result_q[0];
          result_q.delete(0);
          checked_cnt++;
          if (status_o !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, status_o); fail_cnt++;
          end
          if (bin_number_o !== e.bin) begin
            $error("bin_number: expected %0d, got %0d", e.bin, bin_number_o); fail_cnt++;
          end
          if (placed_id_o !== e.id) begin
            $error("placed_id: expected %0d, got %0d", e.id, placed_id_o); fail_cnt++;
          end
          if (placed_amount_o !== e.amount) begin
            $error("placed_amount: expected %0d, got %0d", e.amount, placed_amount_o);
            fail_cnt++;
          end
          if (opened_bin_o !== e.opened) begin
            $error("opened_bin: expected %0d, got %0d", e.opened, opened_bin_o); fail_cnt++;
          end
          if (was_split_o !== e.split) begin
            $error("was_split: expected %0d, got %0d", e.split, was_split_o); fail_cnt++;
          end
          if (items_left_o !== e.left) begin
            $error("items_left: expected %0d, got %0d", e.left, items_left_o); fail_cnt++;
          end
        end
      end
      out_stall_i <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_req(logic [1:0] op, logic [15:0] v, logic [15:0] id);
    pack_req_t req;
    req = '{op, v, id};
    req_q.insert(req_q.size(), req);
  endtask

  // Wait until everything sent has been answered, then let the block settle.
  task automatic drain();
    while (req_q.size() > 0 || in_valid_i || result_q.size() > 0) @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_cfg(logic idx, logic [15:0] data);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_BIN_CAPACITY) capacity = data;
    else min_frag = data;
  endtask

  function automatic logic [15:0] rand_value();
    int unsigned lim;
    lim = (capacity * 2 > 65535) ? 65535 : capacity * 2;
    case ($urandom_range(9))
      0: return 16'd0;
      1: return 16'hffff;
      2: return 16'($urandom);
      default: return 16'($urandom_range(lim));
    endcase
  endfunction

  // Mostly balanced loads and places, some clears and ignored codes.
  task automatic random_mix(int n);
    int sel;
    repeat (n) begin
      sel = $urandom_range(99);
      if (sel < 46) push_req(OP_LOAD, rand_value(), 16'($urandom));
      else if (sel < 94) push_req(OP_PLACE, 16'($urandom), 16'($urandom));
      else if (sel < 97) push_req(OP_CLEAR, 16'($urandom), 16'($urandom));
      else push_req(OpIgnored, 16'($urandom), 16'($urandom));
    end
  endtask

  initial begin
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: defaults (capacity 100, no minimum fragment)
    push_req(OP_PLACE, 16'd5, 16'd5);          // empty list
    push_req(OP_LOAD, 16'd0, 16'd0);
    push_req(OP_PLACE, 16'd0, 16'd0);          // zero-size item opens a bin
    push_req(OP_LOAD, 16'hffff, 16'hffff);
    push_req(OP_PLACE, 16'd0, 16'd0);          // oversized item is split
    push_req(OP_LOAD, 16'd60, 16'd1);
    push_req(OP_LOAD, 16'd150, 16'd2);
    push_req(OP_LOAD, 16'd30, 16'd3);
    push_req(OP_LOAD, 16'd40, 16'd4);
    push_req(OP_PLACE, 16'd0, 16'd0);
    push_req(OP_PLACE, 16'd0, 16'd0);          // no bin fits; opens a bin
    push_req(OP_PLACE, 16'd0, 16'd0);
    push_req(OP_PLACE, 16'd0, 16'd0);
    push_req(OP_PLACE, 16'd0, 16'd0);
    push_req(OpIgnored, 16'hffff, 16'hffff);   // ignored code
    push_req(OP_PLACE, 16'd0, 16'd0);
    push_req(OP_CLEAR, 16'd0, 16'd0);
    push_req(OP_PLACE, 16'd0, 16'd0);
    drain();                                   // sender holds until all answered

    // fill the list past its end and open every bin
    write_cfg(CFG_BIN_CAPACITY, 16'd1);
    write_cfg(CFG_MIN_FRAGMENT, 16'd0);
    for (int k = 0; k <= NumItems; k++) push_req(OP_LOAD, 16'd2, 16'(k));
    repeat (NumBins + 2) push_req(OP_PLACE, 16'd0, 16'd0);
    push_req(OP_CLEAR, 16'd0, 16'd0);
    drain();

    write_cfg(CFG_BIN_CAPACITY, 16'd100);
    write_cfg(CFG_MIN_FRAGMENT, 16'd10);
    sender_idle_pct = 80;
    random_mix(220);
    drain();

    write_cfg(CFG_BIN_CAPACITY, 16'hffff);
    write_cfg(CFG_MIN_FRAGMENT, 16'hffff);
    sender_idle_pct = 0;
    recv_stall_pct = 80;
    random_mix(150);
    drain();

    write_cfg(CFG_BIN_CAPACITY, 16'd50);
    write_cfg(CFG_MIN_FRAGMENT, 16'($urandom_range(1, 20)));
    sender_idle_pct = 18;
    recv_stall_pct = 18;
    random_mix(200);
    drain();

    write_cfg(CFG_BIN_CAPACITY, 16'($urandom_range(1, 65535)));
    write_cfg(CFG_MIN_FRAGMENT, 16'd0);
    sender_idle_pct = 0;
    recv_stall_pct = 0;
    random_mix(60);
    drain();

    $display("run covered %0d results: %0d placements, %0d splits, %0d list-full, %0d exhausted",
             checked_cnt, placed_cnt, split_cnt, full_cnt, exhaust_cnt);
    if (fail_cnt == 0 && result_q.size() == 0) begin
      $display("first_fit_bin_packing_with_splitting_tb: done, clean");
    end else begin
      $display("first_fit_bin_packing_with_splitting_tb: done, errors");
    end
    $finish;
  end

endmodule
